// ===== rtl/hst_pkg.sv =====
`default_nettype none

package hst_pkg;

  localparam int unsigned KEY_IN_W   = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned TYPE_W     = 3;
  localparam int unsigned SLOT_OUT_W = 8;
  // stored info word: valid, kind, type from the lowest bit up
  localparam int unsigned INFO_W     = 1 + KIND_W + TYPE_W;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_WRITE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    hash_step;
    logic    probe_start;
    logic    probe_next;
    logic    rd_en;
    logic    wr_entry;
    logic    clr_wr;
    logic    out_load;
    status_t out_code;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic len_zero;
    logic full;
    logic lookup;
    logic slot_empty;
    logic slot_match;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/hashed_symbol_table_top.sv =====
// Hashed symbol table: open-addressing store keyed by names of up to NAME_BYTES
// characters. A request is hashed one byte per cycle with 32-bit FNV-1a, masked
// to the table size and probed linearly through slot memories with separate
// write and read ports and registered reads. One request is in flight at a time;
// a finished result sits in the output register so the next request can be
// taken while it waits. Each probed slot is first read, then compared; a new
// insert adds a write, and a refused insert (table full) is answered without
// hashing or probing. After reset a clearing pass writes every info slot, one
// per cycle, before the first request is accepted.
`default_nettype none

module hashed_symbol_table_top #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned NAME_BYTES  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // key_bytes[63:0], key_length[67:64], entry_kind[70:68], entry_type[73:71], zero
  input  wire logic [79:0] s_axis_tdata,
  // req_type
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slot_index[7:0], found_kind[10:8], found_type[13:11], zero
  output logic      [15:0] m_axis_tdata,
  // status
  output logic      [1:0]  m_axis_tuser
);

  hst_pkg::cmd_t  cmd;
  hst_pkg::stat_t stat;

  logic [hst_pkg::SLOT_OUT_W-1:0] slot_index;
  logic [hst_pkg::KIND_W-1:0]     found_kind;
  logic [hst_pkg::TYPE_W-1:0]     found_type;

  hst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  hst_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .NAME_BYTES  (NAME_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (s_axis_tuser[0]),
    .in_key_bytes   (s_axis_tdata[63:0]),
    .in_key_length  (s_axis_tdata[67:64]),
    .in_entry_kind  (s_axis_tdata[70:68]),
    .in_entry_type  (s_axis_tdata[73:71]),
    .out_status     (m_axis_tuser),
    .out_slot_index (slot_index),
    .out_found_kind (found_kind),
    .out_found_type (found_type)
  );

  assign m_axis_tdata = {2'b00, found_type, found_kind, slot_index};

endmodule

`default_nettype wire

// ===== rtl/hst_ram.sv =====
`default_nettype none

module hst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hst_ctrl.sv =====
`default_nettype none

module hst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hst_pkg::cmd_t      cmd,
  input  wire hst_pkg::stat_t stat
);

  hst_pkg::state_t  state, state_next;
  hst_pkg::status_t res_code, res_code_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hst_pkg::ST_CLEAR;
      res_code  <= hst_pkg::STAT_NOT_FOUND;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    unique case (state)
      hst_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = hst_pkg::ST_IDLE;
      end
      hst_pkg::ST_IDLE: begin
        if (in_valid) state_next = hst_pkg::ST_HASH;
      end
      hst_pkg::ST_HASH: begin
        // full check comes before any probing
        priority if (!stat.lookup && stat.full) begin
          state_next    = hst_pkg::ST_RESULT;
          res_code_next = hst_pkg::STAT_FULL;
        end else if (stat.len_zero) begin
          state_next = hst_pkg::ST_READ;
        end else begin
          state_next = hst_pkg::ST_HASH;
        end
      end
      hst_pkg::ST_READ: begin
        state_next = hst_pkg::ST_CHECK;
      end
      hst_pkg::ST_CHECK: begin
        // the load limit always leaves an empty slot, so the probe ends
        priority if (stat.slot_empty) begin
          if (stat.lookup) begin
            state_next    = hst_pkg::ST_RESULT;
            res_code_next = hst_pkg::STAT_NOT_FOUND;
          end else begin
            state_next = hst_pkg::ST_WRITE;
          end
        end else if (stat.slot_match) begin
          state_next    = hst_pkg::ST_RESULT;
          res_code_next = hst_pkg::STAT_FOUND;
        end else begin
          state_next = hst_pkg::ST_READ;
        end
      end
      hst_pkg::ST_WRITE: begin
        state_next    = hst_pkg::ST_RESULT;
        res_code_next = hst_pkg::STAT_INSERTED;
      end
      hst_pkg::ST_RESULT: begin
        if (out_free) state_next = hst_pkg::ST_IDLE;
      end
      default: state_next = hst_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.out_code = res_code;
    in_ready     = 1'b0;
    unique case (state)
      hst_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      hst_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      hst_pkg::ST_HASH: begin
        if (stat.lookup || !stat.full) begin
          cmd.hash_step   = !stat.len_zero;
          cmd.probe_start = stat.len_zero;
        end
      end
      hst_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      hst_pkg::ST_CHECK: begin
        cmd.probe_next = !stat.slot_empty && !stat.slot_match;
      end
      hst_pkg::ST_WRITE: begin
        cmd.wr_entry = 1'b1;
      end
      hst_pkg::ST_RESULT: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a stalled transfer");

  a_accept_hash: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == hst_pkg::ST_HASH))
    else $error("accepted request did not start hashing");

  a_write_empty: assert property (@(posedge clk) disable iff (rst)
    (state == hst_pkg::ST_WRITE) |-> ($past(stat.slot_empty) && !$past(stat.lookup)))
    else $error("insert written without an empty slot");
`endif

endmodule

`default_nettype wire

// ===== rtl/hst_dp.sv =====
`default_nettype none

module hst_dp #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned NAME_BYTES  = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire hst_pkg::cmd_t                  cmd,
  output hst_pkg::stat_t                      stat,
  input  wire logic                           in_req_type,
  input  wire logic [hst_pkg::KEY_IN_W-1:0]   in_key_bytes,
  input  wire logic [hst_pkg::LEN_W-1:0]      in_key_length,
  input  wire logic [hst_pkg::KIND_W-1:0]     in_entry_kind,
  input  wire logic [hst_pkg::TYPE_W-1:0]     in_entry_type,
  output logic      [1:0]                     out_status,
  output logic      [hst_pkg::SLOT_OUT_W-1:0] out_slot_index,
  output logic      [hst_pkg::KIND_W-1:0]     out_found_kind,
  output logic      [hst_pkg::TYPE_W-1:0]     out_found_type
);

  localparam int unsigned IDX_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned COUNT_W    = IDX_W + 1;
  localparam int unsigned KEY_W      = 8 * NAME_BYTES;
  localparam int unsigned LOAD_LIMIT = TABLE_SLOTS * 3 / 4;

  logic                        lookup_r;
  logic [KEY_W-1:0]            key_r;
  logic [KEY_W-1:0]            key_sh;
  logic [hst_pkg::LEN_W-1:0]   len_r;
  logic [hst_pkg::KIND_W-1:0]  kind_r;
  logic [hst_pkg::TYPE_W-1:0]  type_r;
  logic [31:0]                 hash;
  logic [31:0]                 hash_next;
  logic [31:0]                 mixed;
  logic [IDX_W-1:0]            idx;
  logic [COUNT_W-1:0]          count;

  logic [KEY_W-1:0]            clean_key;
  logic [hst_pkg::LEN_W-1:0]   clean_len;
  logic [hst_pkg::LEN_W-1:0]   max_len;

  logic [KEY_W-1:0]            name_rd;
  logic [hst_pkg::INFO_W-1:0]  info_rd;
  logic [hst_pkg::INFO_W-1:0]  info_wr;

  // name ends at the clamped length or before its first zero byte
  always_comb begin
    logic alive;
    alive     = 1'b1;
    clean_key = '0;
    clean_len = '0;
    max_len   = (in_key_length > hst_pkg::LEN_W'(NAME_BYTES)) ?
                hst_pkg::LEN_W'(NAME_BYTES) : in_key_length;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (alive && (hst_pkg::LEN_W'(i) < max_len) && (in_key_bytes[8*i +: 8] != 8'h00)) begin
        clean_key[8*i +: 8] = in_key_bytes[8*i +: 8];
        clean_len           = hst_pkg::LEN_W'(i + 1);
      end else begin
        alive = 1'b0;
      end
    end
  end

  assign mixed     = hash ^ {24'd0, key_sh[7:0]};
  assign hash_next = 32'(mixed * hst_pkg::HASH_PRIME);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      lookup_r <= in_req_type;
      key_r    <= clean_key;
      key_sh   <= clean_key;
      len_r    <= clean_len;
      kind_r   <= in_entry_kind;
      type_r   <= in_entry_type;
      hash     <= hst_pkg::HASH_BASIS;
    end else if (cmd.hash_step) begin
      key_sh <= key_sh >> 8;
      len_r  <= len_r - 1'b1;
      hash   <= hash_next;
    end
  end

  // slot pointer doubles as the clear address after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      if (cmd.probe_start) begin
        idx <= hash[IDX_W-1:0];
      end else if (cmd.probe_next || cmd.clr_wr) begin
        idx <= idx + 1'b1;
      end
      if (cmd.wr_entry) begin
        count <= count + 1'b1;
      end
    end
  end

  assign info_wr = cmd.clr_wr ? '0 : {type_r, kind_r, 1'b1};

  hst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_entry),
    .wr_addr (idx),
    .wr_data (key_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx),
    .rd_data (name_rd)
  );

  hst_ram #(
    .WIDTH (hst_pkg::INFO_W),
    .DEPTH (TABLE_SLOTS)
  ) u_info_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_entry || cmd.clr_wr),
    .wr_addr (idx),
    .wr_data (info_wr),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx),
    .rd_data (info_rd)
  );

  always_comb begin
    stat            = '0;
    stat.clr_last   = (idx == {IDX_W{1'b1}});
    stat.len_zero   = (len_r == '0);
    stat.full       = (count >= COUNT_W'(LOAD_LIMIT));
    stat.lookup     = (lookup_r == hst_pkg::REQ_LOOKUP);
    stat.slot_empty = !info_rd[0];
    stat.slot_match = (name_rd == key_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_code;
      unique case (cmd.out_code)
        hst_pkg::STAT_INSERTED: begin
          out_slot_index <= hst_pkg::SLOT_OUT_W'(idx);
          out_found_kind <= kind_r;
          out_found_type <= type_r;
        end
        hst_pkg::STAT_FOUND: begin
          out_slot_index <= hst_pkg::SLOT_OUT_W'(idx);
          out_found_kind <= info_rd[3:1];
          out_found_type <= info_rd[6:4];
        end
        default: begin
          out_slot_index <= '0;
          out_found_kind <= '0;
          out_found_type <= '0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_entry |-> (count < COUNT_W'(LOAD_LIMIT)))
    else $error("entry written past the load limit");
`endif

endmodule

`default_nettype wire

// ===== tb/hashed_symbol_table_top_tb.sv =====
`timescale 1ns / 1ps

module hashed_symbol_table_top_tb;

  localparam int TABLE_SLOTS = 256;
  localparam int NAME_BYTES  = 8;
  localparam int LOAD_LIMIT  = TABLE_SLOTS * 3 / 4;
  localparam int POOL_SIZE   = 320;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + NAME_BYTES + 16;

  typedef struct packed {
    logic        lookup;
    logic [63:0] key;
    logic [3:0]  len;
    logic [2:0]  kind;
    logic [2:0]  etype;
  } req_t;

  typedef struct packed {
    hst_pkg::status_t status;
    logic [7:0]       slot;
    logic [2:0]       kind;
    logic [2:0]       etype;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  hashed_symbol_table_top #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .NAME_BYTES (NAME_BYTES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // shadow copy of the symbol table
  logic [63:0] shadow_name  [TABLE_SLOTS];
  logic        shadow_valid [TABLE_SLOTS];
  logic [2:0]  shadow_kind  [TABLE_SLOTS];
  logic [2:0]  shadow_type  [TABLE_SLOTS];
  int          shadow_count;

  logic [63:0] pool_key [POOL_SIZE];
  int          pool_len [POOL_SIZE];

  result_t pending_results[$];
  int      err_cnt;
  int      req_cnt;
  int      seen_status [4];
  int      snd_idle;
  int      rcv_idle;
  int      hold_req;
  int      hold_seen;
  int      hold_left;
  int      quiet_cycles;

  function automatic logic [31:0] fnv1a(input logic [63:0] key, input int n);
    logic [31:0] h;
    h = hst_pkg::HASH_BASIS;
    for (int i = 0; i < n; i++) begin
      h = h ^ {24'd0, key[8*i +: 8]};
      h = h * hst_pkg::HASH_PRIME;
    end
    return h;
  endfunction

  // applies one request to the shadow table and returns the expected answer
  function automatic result_t table_access(input req_t r);
    logic [63:0] key;
    logic [31:0] h;
    logic [7:0]  idx;
    result_t     res;
    int          lim;
    int          n;
    logic        stop;
    logic        done;
    key  = '0;
    n    = 0;
    stop = 1'b0;
    done = 1'b0;
    res  = '0;
    lim  = (r.len > NAME_BYTES) ? NAME_BYTES : int'(r.len);
    for (int i = 0; i < lim; i++) begin
      if (r.key[8*i +: 8] == 8'h00) stop = 1'b1;
      if (!stop) begin
        key[8*i +: 8] = r.key[8*i +: 8];
        n++;
      end
    end
    if (r.lookup == hst_pkg::REQ_INSERT && shadow_count >= LOAD_LIMIT) begin
      res.status = hst_pkg::STAT_FULL;
      return res;
    end
    h   = fnv1a(key, n);
    idx = h[7:0];
    for (int p = 0; p < TABLE_SLOTS; p++) begin
      if (!done) begin
        if (!shadow_valid[idx]) begin
          done = 1'b1;
          if (r.lookup == hst_pkg::REQ_LOOKUP) begin
            res.status = hst_pkg::STAT_NOT_FOUND;
          end else begin
            shadow_valid[idx] = 1'b1;
            shadow_name[idx]  = key;
            shadow_kind[idx]  = r.kind;
            shadow_type[idx]  = r.etype;
            shadow_count++;
            res.status = hst_pkg::STAT_INSERTED;
            res.slot   = idx;
            res.kind   = r.kind;
            res.etype  = r.etype;
          end
        end else if (shadow_name[idx] == key) begin
          done       = 1'b1;
          res.status = hst_pkg::STAT_FOUND;
          res.slot   = idx;
          res.kind   = shadow_kind[idx];
          res.etype  = shadow_type[idx];
        end else begin
          idx = idx + 8'd1;
        end
      end
    end
    if (!done) begin
      res.status = (r.lookup == hst_pkg::REQ_LOOKUP) ? hst_pkg::STAT_NOT_FOUND :
                                                       hst_pkg::STAT_FULL;
    end
    return res;
  endfunction

  function automatic req_t make_req(input logic lookup, input logic [63:0] key,
                                    input logic [3:0] len, input logic [2:0] kind,
                                    input logic [2:0] etype);
    req_t r;
    r.lookup = lookup;
    r.key    = key;
    r.len    = len;
    r.kind   = kind;
    r.etype  = etype;
    return r;
  endfunction

  // n-th two-character name whose hash lands on the given slot
  function automatic logic [63:0] name_at_slot(input logic [7:0] slot, input int skip);
    logic [63:0] k;
    logic [31:0] h;
    int          hits;
    hits = 0;
    for (int a = 65; a < 91; a++) begin
      for (int b = 1; b < 256; b++) begin
        k = {48'd0, b[7:0], a[7:0]};
        h = fnv1a(k, 2);
        if (h[7:0] == slot) begin
          if (hits == skip) return k;
          hits++;
        end
      end
    end
    return 64'd0;
  endfunction

  // same stored name, but with random junk past its end and a varied length field
  function automatic req_t pool_req(input int i, input logic lookup);
    req_t r;
    int   n;
    n       = pool_len[i];
    r.key   = pool_key[i];
    r.len   = 4'(n);
    r.lookup = lookup;
    r.kind  = 3'($urandom_range(7));
    r.etype = 3'($urandom_range(7));
    for (int b = n; b < 8; b++) r.key[8*b +: 8] = 8'($urandom_range(255));
    if (n < 8 && $urandom_range(1)) begin
      r.key[8*n +: 8] = 8'h00;
      r.len = 4'($urandom_range(15, n));
    end else if (n == 8) begin
      r.len = 4'($urandom_range(15, 8));
    end
    return r;
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r.lookup = 1'($urandom_range(1));
    r.key    = {$urandom, $urandom};
    r.len    = 4'($urandom_range(15));
    r.kind   = 3'($urandom_range(7));
    r.etype  = 3'($urandom_range(7));
    return r;
  endfunction

  // entered and left at a rising edge; valid only drops when a gap is taken
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, r.etype, r.kind, r.len, r.key};
    s_axis_tuser  <= r.lookup;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(table_access(r));
    req_cnt++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = hst_pkg::status_t'(m_axis_tuser);
      got.slot   = m_axis_tdata[7:0];
      got.kind   = m_axis_tdata[10:8];
      got.etype  = m_axis_tdata[13:11];
      seen_status[m_axis_tuser]++;
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected result status %0d slot %0d", $time, got.status, got.slot);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          err_cnt++;
          $display("%0t status exp %0d got %0d", $time, want.status, got.status);
        end
        if (got.slot !== want.slot) begin
          err_cnt++;
          $display("%0t slot_index exp %0d got %0d", $time, want.slot, got.slot);
        end
        if (got.kind !== want.kind) begin
          err_cnt++;
          $display("%0t found_kind exp %0d got %0d", $time, want.kind, got.kind);
        end
        if (got.etype !== want.etype) begin
          err_cnt++;
          $display("%0t found_type exp %0d got %0d", $time, want.etype, got.etype);
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic build_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_len[i] = ($urandom_range(39) == 0) ? 0 : $urandom_range(8, 1);
      pool_key[i] = '0;
      for (int b = 0; b < pool_len[i]; b++)
        pool_key[i][8*b +: 8] = 8'($urandom_range(255, 1));
    end
  endtask

  task automatic test_insert_lookup();
    send_request(make_req(hst_pkg::REQ_LOOKUP, 64'h61, 4'd1, 3'd0, 3'd0));   // empty table
    send_request(make_req(hst_pkg::REQ_INSERT, 64'h61, 4'd1, 3'd7, 3'd7));
    send_request(make_req(hst_pkg::REQ_INSERT, 64'h61, 4'd1, 3'd0, 3'd0));   // kept as is
    send_request(make_req(hst_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FF61, 4'd1, 3'd7, 3'd7));
    send_request(make_req(hst_pkg::REQ_LOOKUP, 64'h62, 4'd1, 3'd0, 3'd0));
  endtask

  task automatic test_name_forms();
    // empty name by zero length, then by a leading zero byte, then all-zero key
    send_request(make_req(hst_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 3'd3, 3'd5));
    send_request(make_req(hst_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 4'd8, 3'd0, 3'd0));
    send_request(make_req(hst_pkg::REQ_INSERT, 64'd0, 4'd8, 3'd1, 3'd1));
    // full-width name, length field clamped
    send_request(make_req(hst_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 3'd0, 3'd7));
    send_request(make_req(hst_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 3'd0, 3'd0));
    send_request(make_req(hst_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 3'd0, 3'd0));
    send_request(make_req(hst_pkg::REQ_INSERT, 64'h8877_6655_4433_2211, 4'd15, 3'd5, 3'd2));
    // zero byte cuts the name short
    send_request(make_req(hst_pkg::REQ_INSERT, 64'h0000_0065_6400_6362, 4'd5, 3'd6, 3'd4));
    send_request(make_req(hst_pkg::REQ_LOOKUP, 64'h0000_0000_0000_6362, 4'd2, 3'd0, 3'd0));
  endtask

  task automatic test_probe_wrap();
    logic [63:0] n0, n1, n2;
    n0 = name_at_slot(8'd255, 0);
    n1 = name_at_slot(8'd255, 1);
    n2 = name_at_slot(8'd255, 2);
    send_request(make_req(hst_pkg::REQ_INSERT, n0, 4'd2, 3'd2, 3'd3));
    send_request(make_req(hst_pkg::REQ_INSERT, n1, 4'd2, 3'd4, 3'd6));   // wraps to slot 0
    send_request(make_req(hst_pkg::REQ_LOOKUP, n1, 4'd2, 3'd0, 3'd0));
    send_request(make_req(hst_pkg::REQ_INSERT, n1, 4'd2, 3'd7, 3'd0));
    send_request(make_req(hst_pkg::REQ_LOOKUP, n2, 4'd2, 3'd0, 3'd0));   // miss after probing
  endtask

  task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
    int i;
    snd_idle = snd_pct;
    rcv_idle = rcv_pct;
    for (int k = 0; k < count; k++) begin
      i = $urandom_range(POOL_SIZE - 1);
      if ($urandom_range(99) < 15)
        send_request(noise_req());
      else
        send_request(pool_req(i, ($urandom_range(99) < 40) ? hst_pkg::REQ_INSERT :
                                                             hst_pkg::REQ_LOOKUP));
    end
  endtask

  task automatic test_backpressure();
    snd_idle = 0;
    hold_req <= hold_req + 1;
    for (int k = 0; k < 24; k++)
      send_request(pool_req($urandom_range(POOL_SIZE - 1), 1'($urandom_range(1))));
  endtask

  task automatic test_table_full();
    req_t r;
    snd_idle = 0;
    rcv_idle = 0;
    while (shadow_count < LOAD_LIMIT) begin
      r = make_req(hst_pkg::REQ_INSERT, {$urandom, $urandom} | 64'h0101_0101_0101_0101,
                   4'd8, 3'($urandom_range(7)), 3'($urandom_range(7)));
      send_request(r);
    end
    send_request(make_req(hst_pkg::REQ_INSERT, 64'h61, 4'd1, 3'd1, 3'd1));   // still refused
    send_request(make_req(hst_pkg::REQ_INSERT, 64'h7A7A7A, 4'd3, 3'd1, 3'd1));
    send_request(make_req(hst_pkg::REQ_LOOKUP, 64'h61, 4'd1, 3'd0, 3'd0));
  endtask

  initial begin
    err_cnt      = 0;
    req_cnt      = 0;
    shadow_count = 0;
    hold_req     = 0;
    hold_seen    = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    snd_idle     = 32;
    rcv_idle     = 61;
    for (int s = 0; s < 4; s++) seen_status[s] = 0;
    for (int s = 0; s < TABLE_SLOTS; s++) shadow_valid[s] = 1'b0;
    build_pool();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_insert_lookup();
    test_name_forms();
    test_probe_wrap();
    test_backpressure();
    test_random(420, 32, 61);
    test_random(420, 61, 32);
    test_table_full();
    test_random(420, 0, 0);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d new inserts, %0d hits, %0d misses, %0d refused inserts",
             req_cnt, seen_status[hst_pkg::STAT_INSERTED], seen_status[hst_pkg::STAT_FOUND],
             seen_status[hst_pkg::STAT_NOT_FOUND], seen_status[hst_pkg::STAT_FULL]);
    $display("table filled to %0d of %0d slots, with probe wrap and a long output stall",
             shadow_count, TABLE_SLOTS);
    if (err_cnt == 0 && pending_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
